// File: hw/rtl/xorshift_index_shuffle_defines.svh
// Assertion macros shared by the shuffle checker.
`ifndef XORSHIFT_INDEX_SHUFFLE_DEFINES_SVH
`define XORSHIFT_INDEX_SHUFFLE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define XIS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define XIS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/xis_pkg.sv
// Types, constants and the generator step for the index shuffle.
`default_nettype none

package xis_pkg;

  localparam int MAX_ITEMS_DEF = 64;
  localparam logic [31:0] DEFAULT_SEED = 32'd2463534242;
  localparam int SHL_A = 13;
  localparam int SHR_B = 17;
  localparam int SHL_C = 5;

  typedef struct packed {
    logic [31:0] seed;
    logic [6:0]  count;
  } in_t;

  typedef struct packed {
    logic [5:0] position;
    logic [5:0] index_value;
    logic       last;
  } out_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [6:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic       done;
    logic [6:0] rem;
  } mod_rsp_t;

  function automatic logic [31:0] xorshift(input logic [31:0] w);
    logic [31:0] x;
    x = w;
    x = x ^ (x << SHL_A);
    x = x ^ (x >> SHR_B);
    x = x ^ (x << SHL_C);
    return x;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/xis_mod.sv
// Iterative remainder unit: 32-bit word modulo a 7-bit divisor, two bits a cycle.
`default_nettype none

module xis_mod (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire xis_pkg::mod_req_t req,
  output xis_pkg::mod_rsp_t     rsp
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [31:0] dvd_r, dvd_nxt;
  logic [6:0]  div_r, div_nxt;
  logic [6:0]  rem_r, rem_nxt;
  logic [6:0]  r1, r2;

  always_comb begin
    // remainder stays below the divisor (at most 64), so six bits carry it
    r1 = {rem_r[5:0], dvd_r[31]};
    if (r1 >= div_r) begin
      r1 = r1 - div_r;
    end
    r2 = {r1[5:0], dvd_r[30]};
    if (r2 >= div_r) begin
      r2 = r2 - div_r;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      dvd_nxt  = req.dividend;
      div_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt  = r2;
      dvd_nxt  = {dvd_r[29:0], 2'b00};
      step_nxt = step_r + 4'd1;
      if (step_r == 4'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    dvd_r  <= dvd_nxt;
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

// File: hw/rtl/xorshift_index_shuffle.sv
// Random index permutation: xorshift32 generator driving a Fisher-Yates shuffle.
//
// Input channel (in_valid/in_ready/in_data): one word holds a seed and a count.
// A zero seed loads the default seed; a count above MAX_ITEMS saturates to it;
// a zero count reloads the generator and yields no results.
// Result channel (out_valid/out_ready/out_data): count words, positions 0 up to
// count-1 in order, each with the original index now at that position; last
// marks the final word.
// One word is worked on at a time. Per input word:
//   the index memory is filled with the identity,
//   then count-1 swaps are made, each paced by the remainder unit,
//   which resolves two bits of the 32-bit draw each cycle,
//   plus the read, read, write, write sequence on the index memory;
//   each result word then takes a memory read, then an output register load.
// in_ready is high only when idle; the last result may still sit in the
// output register while the next word is taken. When the receiver stalls the
// output register holds and emission pauses. Reset returns to idle with no
// result pending and the generator at its default seed; the index memory
// is not cleared.
`default_nettype none

module xorshift_index_shuffle #(
  parameter int MAX_ITEMS = xis_pkg::MAX_ITEMS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire xis_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output xis_pkg::out_t     out_data
);

  localparam int AW = $clog2(MAX_ITEMS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FILL = 4'd1;
  localparam logic [3:0] S_DRAW = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_RDJ  = 4'd4;
  localparam logic [3:0] S_SWAP = 4'd5;
  localparam logic [3:0] S_WRJ  = 4'd6;
  localparam logic [3:0] S_ERD  = 4'd7;
  localparam logic [3:0] S_EOUT = 4'd8;

  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] p_r, p_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic [31:0]   gen_r, gen_nxt;
  logic [5:0]    tp_r, tp_nxt;
  logic          out_valid_r, out_valid_nxt;
  xis_pkg::out_t out_data_r, out_data_nxt;

  logic [5:0]    mem [MAX_ITEMS];
  logic [5:0]    rd_data_r;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [5:0]    wr_data;

  logic [31:0]   draw_word;
  logic [6:0]    count_sat;
  logic          at_last;
  xis_pkg::mod_req_t mod_req;
  xis_pkg::mod_rsp_t mod_rsp;

  xis_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  assign draw_word = xis_pkg::xorshift(gen_r);
  assign count_sat = (in_data.count > 7'(MAX_ITEMS)) ? 7'(MAX_ITEMS) : in_data.count;
  assign at_last   = (7'(p_r) == (cnt_r - 7'd1));

  always_comb begin
    state_nxt     = state_r;
    p_nxt         = p_r;
    j_nxt         = j_r;
    cnt_nxt       = cnt_r;
    gen_nxt       = gen_r;
    tp_nxt        = tp_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = p_r;
    wr_data       = 6'(p_r);
    rd_en         = 1'b0;
    rd_addr       = p_r;
    mod_req.start    = 1'b0;
    mod_req.dividend = draw_word;
    mod_req.divisor  = 7'(p_r) + 7'd1;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // the swap steps run strictly one after another, so no read ever
    // overlaps a pending write to the same entry
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          gen_nxt = (in_data.seed != 32'd0) ? in_data.seed : xis_pkg::DEFAULT_SEED;
          cnt_nxt = count_sat;
          p_nxt   = '0;
          if (count_sat != 7'd0) begin
            state_nxt = S_FILL;
          end
        end
      end
      S_FILL: begin
        wr_en = 1'b1;
        if (at_last) begin
          if (p_r == '0) begin
            state_nxt = S_ERD;
          end else begin
            state_nxt = S_DRAW;
          end
        end else begin
          p_nxt = p_r + 1'b1;
        end
      end
      S_DRAW: begin
        gen_nxt       = draw_word;
        mod_req.start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (mod_rsp.done) begin
          j_nxt     = mod_rsp.rem[AW-1:0];
          rd_en     = 1'b1;
          rd_addr   = p_r;
          state_nxt = S_RDJ;
        end
      end
      S_RDJ: begin
        tp_nxt    = rd_data_r;
        rd_en     = 1'b1;
        rd_addr   = j_r;
        state_nxt = S_SWAP;
      end
      S_SWAP: begin
        wr_en     = 1'b1;
        wr_addr   = p_r;
        wr_data   = rd_data_r;
        state_nxt = S_WRJ;
      end
      S_WRJ: begin
        wr_en   = 1'b1;
        wr_addr = j_r;
        wr_data = tp_r;
        if (p_r == AW'(1)) begin
          p_nxt     = '0;
          state_nxt = S_ERD;
        end else begin
          p_nxt     = p_r - 1'b1;
          state_nxt = S_DRAW;
        end
      end
      S_ERD: begin
        rd_en     = 1'b1;
        rd_addr   = p_r;
        state_nxt = S_EOUT;
      end
      S_EOUT: begin
        // hold the fetched index until the output register frees up
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.position    = 6'(p_r);
          out_data_nxt.index_value = rd_data_r;
          out_data_nxt.last        = at_last;
          if (at_last) begin
            state_nxt = S_IDLE;
          end else begin
            p_nxt     = p_r + 1'b1;
            state_nxt = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      gen_r       <= xis_pkg::DEFAULT_SEED;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      gen_r       <= gen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    j_r        <= j_nxt;
    cnt_r      <= cnt_nxt;
    tp_r       <= tp_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: hw/rtl/xis_checker.sv
// Port-level checker for the index shuffle, bound to the top level.
`default_nettype none
`include "xorshift_index_shuffle_defines.svh"

module xis_checker #(
  parameter int MAX_ITEMS = xis_pkg::MAX_ITEMS_DEF
) (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire xis_pkg::in_t  in_data,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire xis_pkg::out_t out_data
);

  `XIS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result word dropped or changed while stalled")
  `XIS_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && in_ready && (in_data.count != 7'd0), !in_ready, "input taken again before the permutation was emitted")
  `XIS_ASSERT_SAME(a_busy_mid_perm, clk, rst_n, out_valid && !out_data.last, !in_ready, "idle while a permutation is only partly emitted")
  `XIS_ASSERT_SAME(a_out_range, clk, rst_n, out_valid, (32'(out_data.index_value) < 32'(MAX_ITEMS)) && (32'(out_data.position) < 32'(MAX_ITEMS)), "result word outside the index range")

endmodule

bind xorshift_index_shuffle xis_checker #(
  .MAX_ITEMS (MAX_ITEMS)
) u_xis_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
